### hw/rtl/lru_connection_cache_unit_defines.svh
// assertion macros shared by the connection cache rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef LRU_CONNECTION_CACHE_UNIT_DEFINES_SVH
`define LRU_CONNECTION_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define LCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hw/rtl/lcc_pkg.sv
// shared types and constants of the connection cache
// no dependencies; used by every module of the block
`default_nettype none
package lcc_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 8;

  // request kinds
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INVAL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_FILL     = 3'd1;
  localparam logic [2:0] STAT_EVICT    = 3'd2;
  localparam logic [2:0] STAT_CFAIL    = 3'd3;
  localparam logic [2:0] STAT_INVAL    = 3'd4;
  localparam logic [2:0] STAT_NOTFOUND = 3'd5;
  localparam logic [2:0] STAT_CLEARED  = 3'd6;

  // stream widths
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 184;
  localparam int unsigned M_PAD_W   = 4;

  // max age in seconds = (ms >> 3) / 125, done as a multiply by a reciprocal
  localparam int unsigned   THRESH_W    = 23;
  localparam int unsigned   PROD_W      = 59;
  localparam int unsigned   RECIP_SHIFT = 36;
  localparam logic [29:0]   MS_RECIP    = 30'd549755814;

  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  port;
    logic [31:0] tick;
    logic [31:0] opened;
  } entry_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot;
    logic [7:0] ev_addr;
    logic [7:0] ev_port;
    logic       expired;
    logic       inc_hit;
    logic       inc_miss;
    logic       inc_evict;
    logic       inc_inval;
    logic       inc_cfail;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/lcc_entry_mem.sv
// entry memory of the connection cache: key, use tick and open time per slot
// depends on lcc_pkg
`default_nettype none
module lcc_entry_mem #(
  parameter int unsigned POOL_ENTRIES = lcc_pkg::POOL_ENTRIES_DEF,
  localparam int unsigned IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output lcc_pkg::entry_t       rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire lcc_pkg::entry_t  wr_data_i
);

  lcc_pkg::entry_t mem_q [POOL_ENTRIES];
  lcc_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### hw/rtl/lcc_seq.sv
// request sequencer: scans the entry memory, keeps valid bits and use tick,
// builds one result per request of a known kind; depends on lcc_pkg and the defines header
`default_nettype none
`include "lru_connection_cache_unit_defines.svh"
module lcc_seq #(
  parameter int unsigned POOL_ENTRIES = lcc_pkg::POOL_ENTRIES_DEF,
  localparam int unsigned IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    in_req_type_i,
  input  wire logic [7:0]                    in_addr_i,
  input  wire logic [7:0]                    in_port_i,
  input  wire logic                          in_ok_i,
  input  wire logic [31:0]                   in_now_i,
  input  wire logic                          age_en_i,
  input  wire logic [lcc_pkg::THRESH_W-1:0]  thresh_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output lcc_pkg::result_t                   res_o,
  output logic                               mem_rd_en_o,
  output logic [IDX_W-1:0]                   mem_rd_addr_o,
  input  wire lcc_pkg::entry_t               mem_rd_data_i,
  output logic                               mem_wr_en_o,
  output logic [IDX_W-1:0]                   mem_wr_addr_o,
  output lcc_pkg::entry_t                    mem_wr_data_o
);

  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [2:0] slot3(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] ext;
    ext = {3'b000, idx};
    return ext[2:0];
  endfunction

  logic [1:0]              state_q, state_d;
  logic [31:0]             use_tick_q, use_tick_d;
  logic [POOL_ENTRIES-1:0] valid_q, valid_d;
  logic                    ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]        ev_idx_q, ev_idx_d;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic [1:0]              req_q, req_d;
  logic [7:0]              addr_q, addr_d;
  logic [7:0]              port_q, port_d;
  logic                    ok_q, ok_d;
  logic [31:0]             now_q, now_d;
  logic                    free_found_q, free_found_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic                    lru_found_q, lru_found_d;
  logic [IDX_W-1:0]        lru_idx_q, lru_idx_d;
  logic [31:0]             lru_tick_q, lru_tick_d;
  logic [7:0]              lru_addr_q, lru_addr_d;
  logic [7:0]              lru_port_q, lru_port_d;
  logic                    exp_q, exp_d;
  lcc_pkg::result_t        res_q, res_d;

  logic        ent_valid;
  logic        key_match;
  logic [31:0] age;
  logic        aged;

  assign ent_valid = valid_q[ev_idx_q];
  assign key_match = ent_valid && (mem_rd_data_i.addr == addr_q)
                     && (mem_rd_data_i.port == port_q);
  assign age  = now_q - mem_rd_data_i.opened;
  assign aged = age_en_i && (age > {{(32-lcc_pkg::THRESH_W){1'b0}}, thresh_i});

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d      = state_q;
    use_tick_d   = use_tick_q;
    valid_d      = valid_q;
    ev_vld_d     = 1'b0;
    ev_idx_d     = ev_idx_q;
    rd_cnt_d     = rd_cnt_q;
    req_d        = req_q;
    addr_d       = addr_q;
    port_d       = port_q;
    ok_d         = ok_q;
    now_d        = now_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    lru_found_d  = lru_found_q;
    lru_idx_d    = lru_idx_q;
    lru_tick_d   = lru_tick_q;
    lru_addr_d   = lru_addr_q;
    lru_port_d   = lru_port_q;
    exp_d        = exp_q;
    res_d        = res_q;

    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = rd_cnt_q[IDX_W-1:0];
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = ev_idx_q;
    mem_wr_data_o = mem_rd_data_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_type_i;
          addr_d       = in_addr_i;
          port_d       = in_port_i;
          ok_d         = in_ok_i;
          now_d        = in_now_i;
          rd_cnt_d     = '0;
          free_found_d = 1'b0;
          lru_found_d  = 1'b0;
          exp_d        = 1'b0;
          case (in_req_type_i)
            lcc_pkg::REQ_LOOKUP: begin
              use_tick_d = use_tick_q + 32'd1;
              state_d    = ST_SCAN;
            end
            lcc_pkg::REQ_INVAL: begin
              state_d = ST_SCAN;
            end
            lcc_pkg::REQ_CLEAR: begin
              valid_d      = '0;
              res_d        = '0;
              res_d.status = lcc_pkg::STAT_CLEARED;
              state_d      = ST_DONE;
            end
            default: begin
              // unknown request is dropped without a result
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one read per cycle, the entry is judged when its data returns
        if (rd_cnt_q < CNT_W'(POOL_ENTRIES)) begin
          mem_rd_en_o = 1'b1;
          rd_cnt_d    = rd_cnt_q + 1'b1;
          ev_vld_d    = 1'b1;
          ev_idx_d    = rd_cnt_q[IDX_W-1:0];
        end
        if (ev_vld_q) begin
          if (!ent_valid) begin
            if (!free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = ev_idx_q;
            end
          end else if (!lru_found_q || (mem_rd_data_i.tick < lru_tick_q)) begin
            lru_found_d = 1'b1;
            lru_idx_d   = ev_idx_q;
            lru_tick_d  = mem_rd_data_i.tick;
            lru_addr_d  = mem_rd_data_i.addr;
            lru_port_d  = mem_rd_data_i.port;
          end
          if (key_match) begin
            ev_vld_d = 1'b0;
            if (req_q == lcc_pkg::REQ_INVAL) begin
              valid_d[ev_idx_q] = 1'b0;
              res_d             = '0;
              res_d.status      = lcc_pkg::STAT_INVAL;
              res_d.slot        = slot3(ev_idx_q);
              res_d.inc_inval   = 1'b1;
              state_d           = ST_DONE;
            end else if (aged) begin
              valid_d[ev_idx_q] = 1'b0;
              exp_d             = 1'b1;
              if (!free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = ev_idx_q;
              end
              state_d = ST_MISS;
            end else begin
              mem_wr_en_o        = 1'b1;
              mem_wr_data_o.tick = use_tick_q;
              res_d              = '0;
              res_d.status       = lcc_pkg::STAT_HIT;
              res_d.slot         = slot3(ev_idx_q);
              res_d.inc_hit      = 1'b1;
              state_d            = ST_DONE;
            end
          end else if (ev_idx_q == IDX_W'(POOL_ENTRIES - 1)) begin
            ev_vld_d = 1'b0;
            if (req_q == lcc_pkg::REQ_INVAL) begin
              res_d        = '0;
              res_d.status = lcc_pkg::STAT_NOTFOUND;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_MISS;
            end
          end
        end
      end

      ST_MISS: begin
        res_d           = '0;
        res_d.expired   = exp_q;
        res_d.inc_inval = exp_q;
        state_d         = ST_DONE;
        if (!ok_q) begin
          res_d.status    = lcc_pkg::STAT_CFAIL;
          res_d.inc_cfail = 1'b1;
        end else begin
          mem_wr_en_o          = 1'b1;
          mem_wr_data_o.addr   = addr_q;
          mem_wr_data_o.port   = port_q;
          mem_wr_data_o.tick   = use_tick_q;
          mem_wr_data_o.opened = now_q;
          res_d.inc_miss       = 1'b1;
          if (free_found_q) begin
            mem_wr_addr_o       = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
            res_d.status        = lcc_pkg::STAT_FILL;
            res_d.slot          = slot3(free_idx_q);
          end else begin
            mem_wr_addr_o      = lru_idx_q;
            valid_d[lru_idx_q] = 1'b1;
            res_d.status       = lcc_pkg::STAT_EVICT;
            res_d.slot         = slot3(lru_idx_q);
            res_d.ev_addr      = lru_addr_q;
            res_d.ev_port      = lru_port_q;
            res_d.inc_evict    = 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      use_tick_q <= '0;
      valid_q    <= '0;
      ev_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      use_tick_q <= use_tick_d;
      valid_q    <= valid_d;
      ev_vld_q   <= ev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q     <= ev_idx_d;
    rd_cnt_q     <= rd_cnt_d;
    req_q        <= req_d;
    addr_q       <= addr_d;
    port_q       <= port_d;
    ok_q         <= ok_d;
    now_q        <= now_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    lru_found_q  <= lru_found_d;
    lru_idx_q    <= lru_idx_d;
    lru_tick_q   <= lru_tick_d;
    lru_addr_q   <= lru_addr_d;
    lru_port_q   <= lru_port_d;
    exp_q        <= exp_d;
    res_q        <= res_d;
  end

  `LCC_ASSERT_IMP(a_wr_state, clk_i, rst_ni, mem_wr_en_o,
    (state_q == ST_SCAN) || (state_q == ST_MISS), "entry write outside scan or miss")
  `LCC_ASSERT_NEXT(a_fill_valid, clk_i, rst_ni, mem_wr_en_o && (state_q == ST_MISS),
    valid_q[$past(mem_wr_addr_o)], "filled slot not marked valid")
  `LCC_ASSERT_NEXT(a_tick_step, clk_i, rst_ni,
    in_valid_i && in_ready_o && (in_req_type_i == lcc_pkg::REQ_LOOKUP),
    use_tick_q == ($past(use_tick_q) + 32'd1), "use tick did not advance on lookup")

endmodule
`default_nettype wire

### hw/rtl/lru_connection_cache_unit.sv
// Connection cache top level: fully associative table of up to POOL_ENTRIES
// connections keyed by destination address and port, with least recently used
// replacement and optional age expiry. Each accepted request gives exactly one
// result transfer (an unknown request kind gives none). The entries live in a
// single-port-read memory that is scanned one slot per cycle; a matching entry
// ends the scan early at its slot, and a clear needs no scan at all. A new
// request is taken while the previous result still waits in the output
// register. Valid bits sit in flip-flops, so there is no clearing pass after
// reset. The max age register is turned into whole seconds by a multiply
// whose result is registered in thresh_q, behind the max age register.
// Depends on lcc_pkg, lcc_seq, lcc_entry_mem and the defines header.
`default_nettype none
`include "lru_connection_cache_unit_defines.svh"
module lru_connection_cache_unit #(
  parameter int unsigned POOL_ENTRIES = lcc_pkg::POOL_ENTRIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration: max age in milliseconds, zero turns ageing off
  input  wire logic                            cfg_we_i,
  input  wire logic [31:0]                     cfg_wdata_i,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_addr[7:0], key_port[15:8], connect_ok[16], now_seconds[48:17], zero pad
  input  wire logic [lcc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                      s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // slot[2:0], evicted_addr[10:3], evicted_port[18:11], expired[19],
  // hit_count[51:20], miss_count[83:52], eviction_count[115:84],
  // invalidation_count[147:116], connect_fail_count[179:148], zero pad
  output logic [lcc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // status[2:0]
  output logic [2:0]                           m_axis_tuser
);

  localparam int unsigned IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  // config and age threshold
  logic [31:0]                   max_age_q;
  logic [lcc_pkg::THRESH_W-1:0]  thresh_q;
  logic [lcc_pkg::PROD_W-1:0]    age_prod;
  logic                          age_en;

  // ms / 1000 == (ms >> 3) / 125, the latter by reciprocal multiply
  assign age_prod = lcc_pkg::PROD_W'(max_age_q[31:3]) * lcc_pkg::PROD_W'(lcc_pkg::MS_RECIP);
  assign age_en   = (max_age_q != 32'd0);

  // sequencer to output register
  logic             res_valid;
  logic             res_ready;
  lcc_pkg::result_t res;
  logic             capture;

  // entry memory ports
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  lcc_pkg::entry_t  mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  lcc_pkg::entry_t  mem_wr_data;

  // statistics counters
  logic [31:0] hit_cnt_q,   hit_cnt_d;
  logic [31:0] miss_cnt_q,  miss_cnt_d;
  logic [31:0] evict_cnt_q, evict_cnt_d;
  logic [31:0] inval_cnt_q, inval_cnt_d;
  logic [31:0] cfail_cnt_q, cfail_cnt_d;

  // output register
  logic                          out_valid_q;
  logic [lcc_pkg::M_TDATA_W-1:0] out_data_q;
  logic [2:0]                    out_user_q;

  lcc_seq #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_req_type_i (s_axis_tuser),
    .in_addr_i     (s_axis_tdata[7:0]),
    .in_port_i     (s_axis_tdata[15:8]),
    .in_ok_i       (s_axis_tdata[16]),
    .in_now_i      (s_axis_tdata[48:17]),
    .age_en_i      (age_en),
    .thresh_i      (thresh_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  lcc_entry_mem #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // output slot frees as soon as the current transfer is taken
  assign res_ready = !out_valid_q || m_axis_tready;
  assign capture   = res_valid && res_ready;

  // counter values after this result, also what goes out with it
  always_comb begin
    hit_cnt_d   = hit_cnt_q   + {31'd0, res.inc_hit};
    miss_cnt_d  = miss_cnt_q  + {31'd0, res.inc_miss};
    evict_cnt_d = evict_cnt_q + {31'd0, res.inc_evict};
    inval_cnt_d = inval_cnt_q + {31'd0, res.inc_inval};
    cfail_cnt_d = cfail_cnt_q + {31'd0, res.inc_cfail};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q   <= '0;
      thresh_q    <= '0;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      inval_cnt_q <= '0;
      cfail_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      thresh_q <= age_prod[lcc_pkg::RECIP_SHIFT +: lcc_pkg::THRESH_W];
      if (capture) begin
        out_valid_q <= 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
        inval_cnt_q <= inval_cnt_d;
        cfail_cnt_q <= cfail_cnt_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_user_q <= res.status;
      out_data_q <= {{lcc_pkg::M_PAD_W{1'b0}}, cfail_cnt_d, inval_cnt_d, evict_cnt_d,
                     miss_cnt_d, hit_cnt_d, res.expired, res.ev_port, res.ev_addr,
                     res.slot};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `LCC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready,
    res_valid && $stable(res), "pending result dropped or changed")
  `LCC_ASSERT_NEXT(a_clear_keeps_cnt, clk_i, rst_ni,
    capture && (res.status == lcc_pkg::STAT_CLEARED),
    (hit_cnt_q == $past(hit_cnt_q)) && (miss_cnt_q == $past(miss_cnt_q))
    && (inval_cnt_q == $past(inval_cnt_q)), "clear changed statistics")
  `LCC_ASSERT_NEXT(a_hit_count, clk_i, rst_ni,
    capture && (res.status == lcc_pkg::STAT_HIT),
    hit_cnt_q == ($past(hit_cnt_q) + 32'd1), "hit counter did not advance")

endmodule
`default_nettype wire
